@@ design/kpht_pkg.sv @@
`default_nettype none
package kpht_pkg;

	localparam int NUM_KEYS = 8;
	localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CFG_AW = 4;

	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CFG_AW-3:0] REG_PRESS_THR = 2'd0;
	localparam logic [CFG_AW-3:0] REG_RELEASE_THR = 2'd1;
	localparam logic [CFG_AW-3:0] REG_HOLD_PERIOD = 2'd2;

	typedef logic [KEY_AW-1:0] key_addr_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_PRESSED = 3'd1,
		PH_DUE = 3'd2,
		PH_HOLDING = 3'd3,
		PH_RELEASED = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [31:0] start;
	} entry_t;

	typedef struct packed {
		logic [7:0] press_thr;
		logic [7:0] release_thr;
		logic [31:0] hold_period;
	} cfg_t;

	// scan: move one key from its debounce count and the current time
	function automatic entry_t scan_next(entry_t cur, logic [7:0] count, logic [31:0] now,
			cfg_t cfg);
		entry_t nx;
		logic [31:0] elapsed;
		nx = cur;
		elapsed = now - cur.start;
		unique case (cur.phase)
			PH_PRESSED, PH_HOLDING: begin
				if (count < cfg.release_thr) begin
					nx.phase = PH_RELEASED;
				end else if (elapsed >= cfg.hold_period) begin
					nx.phase = PH_DUE;
				end
			end
			PH_DUE: begin
				if (count < cfg.release_thr) begin
					nx.phase = PH_RELEASED;
				end
			end
			PH_RELEASED: begin
				nx.phase = PH_IDLE;
			end
			default: begin
				nx.phase = PH_IDLE;
				if (count > cfg.press_thr) begin
					nx.phase = PH_PRESSED;
					nx.start = now;
				end
			end
		endcase
		return nx;
	endfunction

	// query: consume the reported phase, restart the timer on a due hold
	function automatic entry_t query_next(entry_t cur, logic [31:0] now);
		entry_t nx;
		nx = cur;
		unique case (cur.phase)
			PH_PRESSED, PH_HOLDING: begin
				nx.phase = PH_HOLDING;
			end
			PH_DUE: begin
				nx.phase = PH_HOLDING;
				nx.start = now;
			end
			default: begin
				nx.phase = PH_IDLE;
			end
		endcase
		return nx;
	endfunction

	function automatic phase_t report_of(entry_t cur);
		phase_t r;
		unique case (cur.phase)
			PH_IDLE, PH_PRESSED, PH_DUE, PH_HOLDING, PH_RELEASED: r = cur.phase;
			default: r = PH_IDLE;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/kpht_req_if.sv @@
`default_nettype none
interface kpht_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [2:0] key_index;
	logic [7:0] press_count;
	logic [31:0] now_time;

	modport source (output valid, req_type, key_index, press_count, now_time, input ready);
	modport sink (input valid, req_type, key_index, press_count, now_time, output ready);
endinterface
`default_nettype wire

@@ design/kpht_rsp_if.sv @@
`default_nettype none
interface kpht_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] key_state;
	logic [2:0] result_key;

	modport source (output valid, key_state, result_key, input ready);
	modport sink (input valid, key_state, result_key, output ready);
endinterface
`default_nettype wire

@@ design/kpht_cfg.sv @@
`default_nettype none
module kpht_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [kpht_pkg::CFG_AW-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output kpht_pkg::cfg_t cfg
);
	kpht_pkg::cfg_t cfg_q;
	logic [kpht_pkg::CFG_AW-3:0] reg_idx;
	logic wr;

	assign reg_idx = paddr[kpht_pkg::CFG_AW-1:2];
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_thr <= 8'd200;
			cfg_q.release_thr <= 8'd50;
			cfg_q.hold_period <= 32'd1000;
		end else if (wr) begin
			unique case (reg_idx)
				kpht_pkg::REG_PRESS_THR: cfg_q.press_thr <= pwdata[7:0];
				kpht_pkg::REG_RELEASE_THR: cfg_q.release_thr <= pwdata[7:0];
				kpht_pkg::REG_HOLD_PERIOD: cfg_q.hold_period <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			kpht_pkg::REG_PRESS_THR: prdata = {24'd0, cfg_q.press_thr};
			kpht_pkg::REG_RELEASE_THR: prdata = {24'd0, cfg_q.release_thr};
			kpht_pkg::REG_HOLD_PERIOD: prdata = cfg_q.hold_period;
			default: prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

@@ design/kpht_store.sv @@
`default_nettype none
module kpht_store (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rd_en,
	input wire kpht_pkg::key_addr_t rd_addr,
	output kpht_pkg::entry_t rd_data,
	input wire logic wr_en,
	input wire kpht_pkg::key_addr_t wr_addr,
	input wire kpht_pkg::entry_t wr_data
);
	kpht_pkg::entry_t mem [kpht_pkg::NUM_KEYS];
	kpht_pkg::entry_t mem_rd_q;
	logic [kpht_pkg::NUM_KEYS-1:0] valid_q;
	logic rd_valid_q;
	kpht_pkg::key_addr_t rd_addr_q;
	logic lw_valid_q;
	kpht_pkg::key_addr_t lw_addr_q;
	kpht_pkg::entry_t lw_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
			rd_addr_q <= '0;
			lw_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				lw_valid_q <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
		end
	end

	// the last write always matches memory contents, so forward it on an address hit
	always_comb begin
		if (lw_valid_q && lw_addr_q == rd_addr_q) begin
			rd_data = lw_data_q;
		end else if (rd_valid_q) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data = '{phase: kpht_pkg::PH_IDLE, start: 32'd0};
		end
	end
endmodule
`default_nettype wire

@@ design/key_press_hold_tracker.sv @@
`default_nettype none
// Press / hold / release tracker for NUM_KEYS keys. Each word on req is a scan
// (req_type 0: move the key from its debounce count and the time) or a query
// (req_type 1: report the key's phase and consume it); only queries give a word
// on rsp. One word is taken per cycle, back to back, unless a query waits on a
// full output register; a query's result goes from stage 1 into that register.
// The rate is set by a single read-modify-write of the key entry store (one read
// port, one write port, registered read), with the last write forwarded so
// back-to-back words on the same key see fresh state. Entries read as idle with a
// zero timer until first written; no clearing pass runs after reset. Thresholds
// and the hold period sit on an APB port at byte addresses 0, 4 and 8; write them
// only while the block is idle.
module key_press_hold_tracker (
	input wire logic clk,
	input wire logic arst_n,
	kpht_req_if.sink req,
	kpht_rsp_if.source rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [kpht_pkg::CFG_AW-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	kpht_pkg::cfg_t cfg;

	// stage 1: entry read is in flight, then update and write back
	logic valid_s1;
	logic req_type_s1;
	logic [2:0] key_index_s1;
	logic [7:0] press_count_s1;
	logic [31:0] now_time_s1;
	logic in_range_s1;

	logic out_valid_q;
	logic [2:0] key_state_q;
	logic [2:0] result_key_q;

	logic stall;
	logic advance;
	logic accept;
	logic in_range;
	kpht_pkg::entry_t cur;
	kpht_pkg::entry_t nxt;
	logic wr_en;

	kpht_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.psel (psel),
		.penable (penable),
		.pwrite (pwrite),
		.paddr (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg (cfg)
	);

	kpht_store u_store (
		.clk (clk),
		.arst_n (arst_n),
		.rd_en (accept),
		.rd_addr (kpht_pkg::KEY_AW'(req.key_index)),
		.rd_data (cur),
		.wr_en (wr_en),
		.wr_addr (kpht_pkg::KEY_AW'(key_index_s1)),
		.wr_data (nxt)
	);

	// hold stage 1 only when a query has nowhere to put its result
	assign stall = valid_s1 && req_type_s1 == kpht_pkg::REQ_QUERY && out_valid_q && !rsp.ready;
	assign advance = valid_s1 && !stall;
	assign req.ready = !stall;
	assign accept = req.valid && req.ready;
	assign in_range = int'(req.key_index) < kpht_pkg::NUM_KEYS;

	always_comb begin
		if (req_type_s1 == kpht_pkg::REQ_QUERY) begin
			nxt = kpht_pkg::query_next(cur, now_time_s1);
		end else begin
			nxt = kpht_pkg::scan_next(cur, press_count_s1, now_time_s1, cfg);
		end
	end

	// drop writes for keys beyond the table; they have no entry
	assign wr_en = advance && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			key_index_s1 <= req.key_index;
			press_count_s1 <= req.press_count;
			now_time_s1 <= req.now_time;
			in_range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && req_type_s1 == kpht_pkg::REQ_QUERY) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a key beyond the table reports idle under its own index
	always_ff @(posedge clk) begin
		if (advance && req_type_s1 == kpht_pkg::REQ_QUERY) begin
			key_state_q <= in_range_s1 ? 3'(kpht_pkg::report_of(cur)) : 3'(kpht_pkg::PH_IDLE);
			result_key_q <= key_index_s1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.key_state = key_state_q;
	assign rsp.result_key = result_key_q;

	a_query_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_type_s1 == kpht_pkg::REQ_QUERY |=> out_valid_q)
		else $error("query left stage 1 without a result word");

	a_word_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && req_type_s1 == kpht_pkg::REQ_QUERY))
		else $error("result word without a query");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> int'(key_index_s1) < kpht_pkg::NUM_KEYS)
		else $error("entry write beyond the key table");

	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> key_state_q <= 3'(kpht_pkg::PH_RELEASED))
		else $error("reported key state out of range");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> valid_s1 && $stable(key_index_s1) && $stable(req_type_s1))
		else $error("stage 1 word changed while stalled");
endmodule
`default_nettype wire

@@ tb/key_press_hold_tracker_checker.sv @@
module key_press_hold_tracker_checker (
	input wire logic clk,
	input wire logic arst_n,
	kpht_req_if req,
	kpht_rsp_if rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic pready,
	input wire logic [kpht_pkg::CFG_AW-1:0] paddr,
	input wire logic [31:0] pwdata,
	output int mismatches,
	output int pending,
	output int n_scan,
	output int n_query,
	output int n_checked,
	output int n_due,
	output int n_rel
);
	import kpht_pkg::*;

	typedef struct packed {
		phase_t st;
		logic [2:0] key;
	} key_report_t;

	logic [7:0] press_thr;
	logic [7:0] rel_thr;
	logic [31:0] hold_ticks;
	phase_t key_ph [NUM_KEYS];
	logic [31:0] press_time [NUM_KEYS];
	key_report_t awaited_reports [$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// move one key from its debounce count; release is checked ahead of the hold timer
	task automatic apply_scan(input int k, input logic [7:0] cnt, input logic [31:0] now);
		logic [31:0] waited;
		waited = now - press_time[k];
		case (key_ph[k])
			PH_PRESSED, PH_HOLDING: begin
				if (cnt < rel_thr) key_ph[k] = PH_RELEASED;
				else if (waited >= hold_ticks) key_ph[k] = PH_DUE;
			end
			PH_DUE: begin
				if (cnt < rel_thr) key_ph[k] = PH_RELEASED;
			end
			PH_RELEASED: begin
				key_ph[k] = PH_IDLE;
			end
			default: begin
				if (cnt > press_thr) begin
					key_ph[k] = PH_PRESSED;
					press_time[k] = now;
				end else begin
					key_ph[k] = PH_IDLE;
				end
			end
		endcase
	endtask

	// report the phase, then consume it; a due hold restarts the timer
	task automatic apply_query(input int k, input logic [31:0] now);
		key_report_t r;
		r.key = k[2:0];
		r.st = (k < NUM_KEYS) ? key_ph[k] : PH_IDLE;
		awaited_reports.push_back(r);
		if (k < NUM_KEYS) begin
			case (key_ph[k])
				PH_PRESSED, PH_HOLDING: key_ph[k] = PH_HOLDING;
				PH_DUE: begin
					key_ph[k] = PH_HOLDING;
					press_time[k] = now;
				end
				default: key_ph[k] = PH_IDLE;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_report_t head;
		if (!arst_n) begin
			press_thr = 8'd200;
			rel_thr = 8'd50;
			hold_ticks = 32'd1000;
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_ph[i] = PH_IDLE;
				press_time[i] = 32'd0;
			end
			awaited_reports.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch("unexpected report word", rsp.key_state, -1);
				end else begin
					head = awaited_reports.pop_front();
					n_checked++;
					if (head.st == PH_DUE) n_due++;
					if (head.st == PH_RELEASED) n_rel++;
					if (rsp.key_state !== head.st)
						report_mismatch("key_state", rsp.key_state, head.st);
					if (rsp.result_key !== head.key)
						report_mismatch("result_key", rsp.result_key, head.key);
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_SCAN) begin
					n_scan++;
					if (req.key_index < NUM_KEYS)
						apply_scan(req.key_index, req.press_count, req.now_time);
				end else begin
					n_query++;
					apply_query(req.key_index, req.now_time);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_AW-1:2])
					REG_PRESS_THR: press_thr = pwdata[7:0];
					REG_RELEASE_THR: rel_thr = pwdata[7:0];
					REG_HOLD_PERIOD: hold_ticks = pwdata;
					default: ;
				endcase
			end
			pending = awaited_reports.size();
		end
	end

endmodule

@@ tb/key_press_hold_tracker_tb.sv @@
module key_press_hold_tracker_tb;
	import kpht_pkg::*;

	// longest quiet stretch of a correct run is the long receiver hold (LONG_HOLD)
	// plus a config pause; take that several times over
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 200;
	localparam int PHASE_WORDS = 220;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int mismatches;
	int pending;
	int n_scan;
	int n_query;
	int n_checked;
	int n_due;
	int n_rel;

	int tx_idle_pct;
	int rx_idle_pct;
	int stalls_asked;
	int stalls_done;
	int sent;
	int idle_cycles;

	// stimulus-side copy of the current settings, used only to shape words
	logic [7:0] cur_press;
	logic [7:0] cur_rel;
	logic [31:0] cur_hold;
	logic [31:0] tick;

	kpht_req_if req_ch ();
	kpht_rsp_if rsp_ch ();

	key_press_hold_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	key_press_hold_tracker_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.pending(pending),
		.n_scan(n_scan),
		.n_query(n_query),
		.n_checked(n_checked),
		.n_due(n_due),
		.n_rel(n_rel)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// watchdog: reset the count on any accepted word or register access
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d reports pending",
				idle_cycles, pending);
			$display("key_press_hold_tracker_tb: done, errors");
			$finish;
		end
	end

	// receiver: idle at random, or hold off for a long stretch when asked
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_asked != stalls_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				stalls_done++;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// clamp an empty range to its nearest legal count
	function automatic logic [7:0] pick(input int lo, input int hi);
		if (lo > 255) lo = 255;
		if (hi < 0) hi = 0;
		if (hi < lo) hi = lo;
		return 8'($urandom_range(hi, lo));
	endfunction

	// advance time around the hold period so due / not-due both happen
	function automatic logic [31:0] time_step();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom_range(1, 3);
			2: return cur_hold;
			3: return cur_hold + $urandom_range(0, 2);
			4: return cur_hold >> 1;
			default: return $urandom;
		endcase
	endfunction

	// offer one word, with random sender gaps; return at the negedge after acceptance
	task automatic send_word(input logic rt, input logic [2:0] k, input logic [7:0] cnt,
			input logic [31:0] now);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.key_index <= k;
		req_ch.press_count <= cnt;
		req_ch.now_time <= now;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	// setup then access phase; finish on a fresh negedge so back-to-back writes stay clean
	task automatic apb_write(input logic [CFG_AW-3:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// drain all reports, let the pipe empty of scans, then write every register
	task automatic reconfigure(input logic [7:0] p, input logic [7:0] r, input logic [31:0] h);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		apb_write(REG_PRESS_THR, {24'd0, p});
		apb_write(REG_RELEASE_THR, {24'd0, r});
		apb_write(REG_HOLD_PERIOD, h);
		cur_press = p;
		cur_rel = r;
		cur_hold = h;
	endtask

	// one well-formed press / hold / release pass on a key, with random content
	task automatic key_cycle(input logic [2:0] k);
		int steps;
		steps = $urandom_range(1, 6);
		tick += time_step();
		send_word(REQ_SCAN, k, pick(cur_press + 1, 255), tick);
		repeat (steps) begin
			tick += time_step();
			case ($urandom_range(0, 3))
				0, 1: send_word(REQ_SCAN, k, pick(cur_rel, 255), tick);
				2: send_word(REQ_QUERY, k, 8'($urandom_range(0, 255)), tick);
				default: send_word(REQ_SCAN, k, 8'($urandom_range(0, 255)), tick);
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			tick += time_step();
			send_word(REQ_SCAN, k, pick(0, cur_rel - 1), tick);
			if ($urandom_range(0, 1) == 0)
				send_word(REQ_QUERY, k, 8'($urandom_range(0, 255)), tick);
			else
				send_word(REQ_SCAN, k, 8'($urandom_range(0, 255)), tick);
		end
		if ($urandom_range(0, 1) == 0)
			send_word(REQ_QUERY, k, 8'($urandom_range(0, 255)), tick);
	endtask

	initial begin
		int target;
		logic [7:0] np;
		logic [7:0] nr;
		logic [31:0] nh;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SCAN;
		req_ch.key_index = 3'd0;
		req_ch.press_count = 8'd0;
		req_ch.now_time = 32'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		idle_cycles = 0;
		stalls_asked = 0;
		stalls_done = 0;
		sent = 0;
		tick = 32'd0;
		cur_press = 8'd200;
		cur_rel = 8'd50;
		cur_hold = 32'd1000;
		tx_idle_pct = 12;
		rx_idle_pct = 59;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset settings: threshold edges, hold due, auto-repeat, release
		send_word(REQ_SCAN, 3'd0, 8'd200, 32'd100);
		send_word(REQ_SCAN, 3'd0, 8'd201, 32'd100);
		send_word(REQ_QUERY, 3'd0, 8'd0, 32'd150);
		send_word(REQ_QUERY, 3'd0, 8'd255, 32'd160);
		send_word(REQ_SCAN, 3'd0, 8'd50, 32'd1099);
		send_word(REQ_SCAN, 3'd0, 8'd255, 32'd1100);
		send_word(REQ_SCAN, 3'd0, 8'd60, 32'd1200);
		send_word(REQ_QUERY, 3'd0, 8'd17, 32'd1300);
		send_word(REQ_SCAN, 3'd0, 8'd128, 32'd2299);
		// release beats a hold that became due on the same scan
		send_word(REQ_SCAN, 3'd0, 8'd49, 32'd2300);
		send_word(REQ_QUERY, 3'd0, 8'd0, 32'd2301);
		send_word(REQ_SCAN, 3'd7, 8'd0, 32'd0);
		send_word(REQ_QUERY, 3'd7, 8'd255, 32'hFFFF_FFFF);
		// elapsed time across the 32-bit wrap
		send_word(REQ_SCAN, 3'd1, 8'd255, 32'hFFFF_FF00);
		send_word(REQ_SCAN, 3'd1, 8'd128, 32'h0000_02E8);
		send_word(REQ_SCAN, 3'd1, 8'd0, 32'h0000_02E9);
		send_word(REQ_SCAN, 3'd1, 8'd255, 32'h0000_02EA);
		send_word(REQ_QUERY, 3'd1, 8'd0, 32'h0000_02EB);
		send_word(REQ_SCAN, 3'd2, 8'd255, 32'd0);
		send_word(REQ_SCAN, 3'd2, 8'd0, 32'd5000);
		send_word(REQ_SCAN, 3'd2, 8'd0, 32'd5001);
		send_word(REQ_QUERY, 3'd2, 8'd0, 32'd5002);

		// directed, extreme settings: no press possible, then zero hold period
		reconfigure(8'd255, 8'd50, 32'd0);
		send_word(REQ_SCAN, 3'd3, 8'd255, 32'h5555_5555);
		send_word(REQ_QUERY, 3'd3, 8'd0, 32'hAAAA_AAAA);
		reconfigure(8'd0, 8'd50, 32'd0);
		send_word(REQ_SCAN, 3'd3, 8'd1, 32'd10);
		send_word(REQ_SCAN, 3'd3, 8'd50, 32'd10);
		send_word(REQ_QUERY, 3'd3, 8'd0, 32'd11);

		// random phases: several settings, idle pattern moving from sender-light
		// to receiver-light to none
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin np = 8'd128; nr = 8'd64; nh = 32'd16; end
				1: begin np = 8'd0; nr = 8'd255; nh = 32'd0; end
				2: begin np = 8'd254; nr = 8'd0; nh = 32'hFFFF_FFFF; end
				3: begin np = 8'd100; nr = 8'd100; nh = 32'd5; end
				4: begin
					np = 8'($urandom_range(0, 255));
					nr = 8'($urandom_range(0, 255));
					nh = $urandom_range(0, 64);
				end
				default: begin np = 8'd200; nr = 8'd50; nh = 32'd1000; end
			endcase
			reconfigure(np, nr, nh);
			if (ph < 2) begin
				tx_idle_pct = 12;
				rx_idle_pct = 59;
			end else if (ph < 4) begin
				tx_idle_pct = 59;
				rx_idle_pct = 12;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// hold off the receiver while words keep coming, so the block backs up
			if (ph == 4) stalls_asked++;
			target = sent + PHASE_WORDS;
			while (sent < target) begin
				if ($urandom_range(0, 4) == 0) begin
					send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)), $urandom);
				end else begin
					key_cycle(3'($urandom_range(0, 7)));
				end
			end
		end

		// drain and let the tail settle
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d words: %0d scans, %0d queries; %0d reports checked",
			sent, n_scan, n_query, n_checked);
		$display("reports seen hold-due %0d, released %0d, across 8 register settings",
			n_due, n_rel);
		if (mismatches == 0) begin
			$display("key_press_hold_tracker_tb: done, clean");
		end else begin
			$display("key_press_hold_tracker_tb: done, errors");
		end
		$finish;
	end

endmodule

@@ key_press_hold_tracker.f @@
design/kpht_pkg.sv
design/kpht_req_if.sv
design/kpht_rsp_if.sv
design/kpht_cfg.sv
design/kpht_store.sv
design/key_press_hold_tracker.sv
tb/key_press_hold_tracker_checker.sv
tb/key_press_hold_tracker_tb.sv
